// ===== rtl/vlpra_pkg.sv =====
// Shared types and constants for the value list block.
// Holds the request and result item types and the control and status structs.
// Depends on nothing.
`default_nettype none

package vlpra_pkg;

	localparam int unsigned DEPTH_DEF = 256;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned LEN_W     = 9;

	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             full_drop;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic push;
		logic scan_rd;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_done;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/vlpra_dpath.sv =====
// Datapath: entry memory, length count, scan pointers and result fields.
// Depends on vlpra_pkg.
`default_nettype none

module vlpra_dpath import vlpra_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     request,
	input  wire ctl_cmd_t cmd,
	output ctl_sts_t      sts,
	output rsp_t          result
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VAL_W-1:0] mem [DEPTH];

	logic [VAL_W-1:0] value_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_q;
	logic [CW-1:0]    wr_q;
	logic             drop_q;
	logic             rd_vld_s1;
	logic [VAL_W-1:0] rd_data_s1;

	logic             full;
	logic             keep;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	logic [CW+LEN_W-1:0] len_ext;

	assign full  = (count_q == CW'(DEPTH));
	// survivor of the scan: copy it down to the write pointer
	assign keep  = rd_vld_s1 && (rd_data_s1 != value_q);
	assign we    = (cmd.push && !full) || keep;
	assign waddr = cmd.push ? count_q[AW-1:0] : wr_q[AW-1:0];
	assign wdata = cmd.push ? value_q : rd_data_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem[rd_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= request.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			drop_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				rd_q   <= '0;
				wr_q   <= '0;
				drop_q <= 1'b0;
			end
			if (cmd.push) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.scan_rd) begin
				rd_q <= rd_q + CW'(1);
			end
			if (keep) begin
				wr_q <= wr_q + CW'(1);
			end
			if (cmd.commit) begin
				count_q <= wr_q;
			end
		end
	end

	assign sts.rd_done = (rd_q == count_q);

	assign len_ext          = (CW+LEN_W)'(count_q);
	assign result.length    = len_ext[LEN_W-1:0];
	assign result.full_drop = drop_q;

endmodule

`default_nettype wire

// ===== rtl/vlpra_ctrl.sv =====
// Controller: sequences push, scan-and-compact and the result strobe.
// Depends on vlpra_pkg.
`default_nettype none

module vlpra_ctrl import vlpra_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     opcode,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (opcode == OP_PUSH) ? ST_PUSH : ST_SCAN;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_RESP;
			end
			ST_SCAN: begin
				if (sts.rd_done) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= (state_d == ST_RESP);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/value_list_push_remove_all.sv =====
// Top level of the value list: ordered list with append and remove-all.
// Instantiates vlpra_ctrl and vlpra_dpath; depends on vlpra_pkg.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+--------------------------------------
//   request   | start, busy, request   | item taken when start && !busy
//   result    | done, result           | one-cycle strobe, cannot be held off
//
// Sequence: a push loads the value, appends it in the push state and strobes the
//   result in the result state before the block returns to idle.
// A remove scans the n held entries one entry a cycle through the single read
//   port of the entry memory, spots the end while the last compare lands,
//   passes a drain state, commits the new length and strobes the result.
// Reset: arst_n clears the length, the controller and the strobes; the entry
//   memory is not cleared, since only entries below the length are ever read.
// Stalls: busy stays high from accept through the strobe cycle and drops in
//   the cycle after it.
`default_nettype none

module value_list_push_remove_all import vlpra_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      result
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequence the item: load, push or scan and commit, strobe
	vlpra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold the entries and the length; compact survivors in place
	vlpra_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== rtl/vlpra_chk.sv =====
// Port-level checker for the value list, bound to the top level.
// Depends on vlpra_pkg.
`default_nettype none

module vlpra_chk import vlpra_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t request,
	input wire logic done,
	input wire rsp_t result
);

	localparam int unsigned DW = $clog2(DEPTH + 1) + LEN_W;
	localparam logic [DW-1:0] DEPTH_EXT = DW'(DEPTH);

	// an accepted item holds off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// checks when the push result strobes relative to accept
	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.opcode == OP_PUSH) |-> ##2 done)
		else $error("push result not on time");

	// the block frees up right after the strobe
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("busy or strobe held after result");

	// a dropped push reports a full list
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.full_drop |-> (result.length == DEPTH_EXT[LEN_W-1:0]))
		else $error("drop flagged below full length");

endmodule

bind value_list_push_remove_all vlpra_chk #(.DEPTH(DEPTH)) u_chk (.*);

`default_nettype wire
